// File: hdl/sec_pkg.sv
// ----------------------------------------------------------------------------
// sec_pkg: shared types and constants for the subdivision element counter
// Field widths, configuration register indexes and the records that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package sec_pkg;

  localparam int unsigned MAX_DEPTH  = 15;
  localparam int unsigned DEPTH_W    = 4;
  localparam int unsigned CAGE_W     = 20;
  localparam int unsigned CNT_W      = 31;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 312;
  localparam int unsigned REG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CAGE_VERTICES  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAGE_EDGES     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAGE_HALFEDGES = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAGE_FACES     = 2'd3;

  typedef struct packed {
    logic [CAGE_W-1:0] v;
    logic [CAGE_W-1:0] e;
    logic [CAGE_W-1:0] h;
    logic [CAGE_W-1:0] f;
  } cage_t;

  // Per-depth factors: a = 2^d-1, b = (4^d-1)/3, k = b-a, t = 2^(d-1)-1
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [14:0]        a;
    logic [28:0]        b;
    logic [28:0]        k;
    logic [13:0]        t;
  } dec_t;

  typedef struct packed {
    logic               d_zero;
    logic [DEPTH_W-1:0] sh;
    logic [13:0]        t;
    logic [49:0]        faces;
    logic [49:0]        halfs;
    logic [34:0]        creases;
    logic [34:0]        ah;
    logic [33:0]        tf;
    logic [48:0]        bh;
    logic [36:0]        ae1;
    logic [48:0]        kh;
    logic [34:0]        ae;
    logic signed [37:0] adh;
    logic signed [26:0] dv;
  } prod_t;

  typedef struct packed {
    logic               d_zero;
    logic [49:0]        faces;
    logic [49:0]        edges;
    logic [49:0]        halfs;
    logic [34:0]        creases;
    logic [48:0]        vmul;
    logic [50:0]        thalf;
    logic [48:0]        tfaces;
    logic [50:0]        tedges;
    logic [35:0]        tcreases;
    logic signed [51:0] tvert;
  } sum_t;

endpackage

// File: hdl/sec_cfg_regs.sv
// ----------------------------------------------------------------------------
// sec_cfg_regs: cage count registers
// Holds the four control cage counts written through the plain write port.
// ----------------------------------------------------------------------------
module sec_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [sec_pkg::REG_IDX_W-1:0]  idx_i,
  input  logic [sec_pkg::CAGE_W-1:0]     data_i,
  output sec_pkg::cage_t                 cage_o
);
  import sec_pkg::*;

  cage_t cage_q, cage_d;

  always_comb begin
    cage_d = cage_q;
    if (we_i) begin
      unique case (idx_i)
        REG_CAGE_VERTICES:  cage_d.v = data_i;
        REG_CAGE_EDGES:     cage_d.e = data_i;
        REG_CAGE_HALFEDGES: cage_d.h = data_i;
        REG_CAGE_FACES:     cage_d.f = data_i;
        default:            cage_d = cage_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cage_q <= '0;
    end else begin
      cage_q <= cage_d;
    end
  end

  assign cage_o = cage_q;

endmodule

// File: hdl/sec_decode.sv
// ----------------------------------------------------------------------------
// sec_decode: depth decode stage
// Clamp the depth and expand it into the power-series factors.
// ----------------------------------------------------------------------------
module sec_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [sec_pkg::DEPTH_W-1:0]     depth_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output sec_pkg::dec_t                   data_o
);
  import sec_pkg::*;

  logic               valid_q;
  dec_t               data_q, data_d;
  logic [DEPTH_W-1:0] depth;

  always_comb begin
    depth = (depth_i > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth_i;
    data_d       = '0;
    data_d.depth = depth;
    // a has the low d bits set, b has every even bit below 2d set
    for (int i = 0; i < 15; i++) begin
      data_d.a[i]   = (DEPTH_W'(i) < depth);
      data_d.b[2*i] = (DEPTH_W'(i) < depth);
    end
    data_d.k = data_d.b - 29'(data_d.a);
    data_d.t = data_d.a[14:1];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/sec_mul.sv
// ----------------------------------------------------------------------------
// sec_mul: product stage
// Form every factor-by-count product and the plain shifted counts.
// ----------------------------------------------------------------------------
module sec_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sec_pkg::cage_t cage_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  sec_pkg::dec_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output sec_pkg::prod_t data_o
);
  import sec_pkg::*;

  logic               valid_q;
  prod_t              data_q, data_d;
  logic [21:0]        e1;
  logic signed [21:0] e_minus_h;
  logic signed [21:0] v_minus_e_plus_f;

  always_comb begin
    e1               = {1'b0, cage_i.e, 1'b0} + 22'(cage_i.h);
    e_minus_h        = signed'({1'b0, cage_i.e, 1'b0}) - signed'(22'(cage_i.h));
    v_minus_e_plus_f = signed'(22'(cage_i.v)) - signed'(22'(cage_i.e))
                     + signed'(22'(cage_i.f));

    data_d.d_zero = (data_i.depth == '0);
    data_d.sh     = data_d.d_zero ? '0 : data_i.depth - DEPTH_W'(1);
    data_d.t      = data_i.t;
    data_d.faces  = data_d.d_zero ? 50'(cage_i.f) : (50'(cage_i.h) << {data_d.sh, 1'b0});
    data_d.halfs  = 50'(cage_i.h) << {data_i.depth, 1'b0};
    data_d.creases = 35'(cage_i.e) << data_i.depth;
    data_d.ah     = 35'(data_i.a) * 35'(cage_i.h);
    data_d.tf     = 34'(data_i.t) * 34'(cage_i.h);
    data_d.bh     = 49'(data_i.b) * 49'(cage_i.h);
    data_d.ae1    = 37'(data_i.a) * 37'(e1);
    data_d.kh     = 49'(data_i.k) * 49'(cage_i.h);
    data_d.ae     = 35'(data_i.a) * 35'(cage_i.e);
    data_d.adh    = 38'(signed'({1'b0, data_i.a})) * 38'(e_minus_h);
    data_d.dv     = 27'(signed'({1'b0, data_i.depth})) * 27'(v_minus_e_plus_f);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/sec_sum.sv
// ----------------------------------------------------------------------------
// sec_sum: combine stage
// Add the products into the closed forms; second product of the vertex count.
// ----------------------------------------------------------------------------
module sec_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sec_pkg::cage_t cage_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  sec_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output sec_pkg::sum_t  data_o
);
  import sec_pkg::*;

  logic        valid_q;
  sum_t        data_q, data_d;
  logic [35:0] edge_base;
  logic [34:0] vert_inner;

  always_comb begin
    edge_base  = 36'({cage_i.e, 1'b0}) + 36'(data_i.ah);
    vert_inner = 35'({1'b0, cage_i.e, 1'b0}) + 35'(cage_i.h) + 35'(data_i.tf);

    data_d.d_zero   = data_i.d_zero;
    data_d.faces    = data_i.faces;
    data_d.halfs    = data_i.halfs;
    data_d.creases  = data_i.creases;
    data_d.edges    = data_i.d_zero ? 50'(cage_i.e) : (50'(edge_base) << data_i.sh);
    data_d.vmul     = 49'(data_i.t) * 49'(vert_inner);
    data_d.thalf    = {data_i.bh, 2'b00};
    data_d.tfaces   = data_i.bh;
    data_d.tedges   = 51'(data_i.ae1) + 51'({data_i.kh, 1'b0});
    data_d.tcreases = {data_i.ae, 1'b0};
    data_d.tvert    = 52'(data_i.adh) + signed'(52'(data_i.bh)) + 52'(data_i.dv);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/sec_sat.sv
// ----------------------------------------------------------------------------
// sec_sat: saturate and output stage
// Clamp every count to 31 bits, collect the overflow flag, pack the result.
// ----------------------------------------------------------------------------
module sec_sat (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sec_pkg::cage_t                     cage_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  sec_pkg::sum_t                      data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [sec_pkg::OUT_TDATA_W-1:0]    data_o
);
  import sec_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Return {overflow, clamped value}
  function automatic logic [CNT_W:0] sat_u(input logic [51:0] v);
    if (|v[51:CNT_W]) begin
      sat_u = {1'b1, CNT_MAX};
    end else begin
      sat_u = {1'b0, v[CNT_W-1:0]};
    end
  endfunction

  function automatic logic [CNT_W:0] sat_s(input logic signed [51:0] v);
    if (v[51]) begin
      sat_s = {1'b1, {CNT_W{1'b0}}};
    end else if (|v[50:CNT_W]) begin
      sat_s = {1'b1, CNT_MAX};
    end else begin
      sat_s = {1'b0, v[CNT_W-1:0]};
    end
  endfunction

  logic                      valid_q;
  logic [OUT_TDATA_W-1:0]    data_q, data_d;
  logic [21:0]               v1;
  logic [49:0]               verts;
  logic [CNT_W:0]            s_fa, s_ed, s_ha, s_cr, s_ve, s_th, s_tf, s_te, s_tc, s_tv;
  logic                      ovf;

  always_comb begin
    v1    = 22'(cage_i.v) + 22'(cage_i.e) + 22'(cage_i.f);
    verts = data_i.d_zero ? 50'(cage_i.v) : 50'(data_i.vmul) + 50'(v1);
    s_fa  = sat_u(52'(data_i.faces));
    s_ed  = sat_u(52'(data_i.edges));
    s_ha  = sat_u(52'(data_i.halfs));
    s_cr  = sat_u(52'(data_i.creases));
    s_ve  = sat_u(52'(verts));
    s_th  = sat_u(52'(data_i.thalf));
    s_tf  = sat_u(52'(data_i.tfaces));
    s_te  = sat_u(52'(data_i.tedges));
    s_tc  = sat_u(52'(data_i.tcreases));
    s_tv  = sat_s(data_i.tvert);
    ovf   = s_fa[CNT_W] | s_ed[CNT_W] | s_ha[CNT_W] | s_cr[CNT_W] | s_ve[CNT_W]
          | s_th[CNT_W] | s_tf[CNT_W] | s_te[CNT_W] | s_tc[CNT_W] | s_tv[CNT_W];
    data_d = {1'b0, ovf,
              s_tv[CNT_W-1:0], s_tc[CNT_W-1:0], s_te[CNT_W-1:0], s_tf[CNT_W-1:0],
              s_th[CNT_W-1:0], s_ve[CNT_W-1:0], s_cr[CNT_W-1:0], s_ha[CNT_W-1:0],
              s_ed[CNT_W-1:0], s_fa[CNT_W-1:0]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/subdivision_element_counts_core.sv
// ----------------------------------------------------------------------------
// subdivision_element_counts_core: per-level element counts of a quad
// subdivision hierarchy
//
// Usage:
//   - Write the cage vertex, edge, halfedge and face counts through the
//     cfg_we_i / cfg_idx_i / cfg_data_i port while the block is idle
//     (indexes 0..3 in that order); each write lands at the clock edge.
//   - Send one depth per transfer on the s_axis group. Each transfer yields
//     one result transfer on the m_axis group: counts at that depth, the
//     cumulative counts of levels 1..depth and a saturation flag.
//   - Four register stages: depth decode, products, sums, saturate/output.
//     A result passes through these registers in that order; the block
//     takes one depth every cycle while the receiver accepts results.
//   - When the receiver stalls, each stage holds until the stage after it
//     frees up; s_axis_tready stays high while any stage is empty, so
//     bubbles are squeezed out and no transfer is dropped or repeated.
//   - Reset clears the cage registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module subdivision_element_counts_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [sec_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sec_pkg::CAGE_W-1:0]         cfg_data_i,
  // Depth requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [3:0] depth, [7:4] zero
  // Count results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [30:0] faces_at, [61:31] edges_at, [92:62] halfedges_at,
  // [123:93] creases_at, [154:124] vertices_at, [185:155] total_halfedges,
  // [216:186] total_faces, [247:217] total_edges, [278:248] total_creases,
  // [309:279] total_vertices, [310] overflowed, [311] zero
  output logic [sec_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import sec_pkg::*;

  cage_t cage;
  dec_t  s1_data;
  prod_t s2_data;
  sum_t  s3_data;
  logic  s1_valid, s1_ready;
  logic  s2_valid, s2_ready;
  logic  s3_valid, s3_ready;

  // The user must hold the cage counts constant while items are in flight; the
  // block does not enforce it. Stages 2-4 read them straight from the registers.
  sec_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cage_o (cage)
  );

  // Stage 1: clamp depth, build 2^d-1, (4^d-1)/3 and friends
  sec_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .depth_i (s_axis_tdata[DEPTH_W-1:0]),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage 2: one multiplier per product term
  sec_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cage_i  (cage),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stage 3: sums of the closed forms, second factor of the vertex count
  sec_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cage_i  (cage),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // Stage 4: saturate to 31 bits and hold the result for the receiver
  sec_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cage_i  (cage),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // Backpressure reaches the input only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid && s2_valid && s3_valid && m_axis_tvalid))
    else $error("input stalled with an empty pipeline stage");

  // Unsaturated cumulative halfedges are exactly four times the faces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[310]) |->
      (m_axis_tdata[185:155] == {m_axis_tdata[214:186], 2'b00}))
    else $error("total halfedges and total faces disagree");

  // Unsaturated cumulative creases are always even
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[310]) |-> !m_axis_tdata[248])
    else $error("odd total crease count");
`endif

endmodule
